FILE: rtl/sactl_pkg.sv
`default_nettype none

package sactl_pkg;

    // one memory row holds this many lines, enough for the widest set
    localparam int ROW_W = 8;
    localparam int LANE_W = 3;

    // set index field and its largest usable width
    localparam int SET_W = 9;
    localparam logic [3:0] MAX_SET_BITS = 4'd9;

    // victim lfsr seed
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // configuration register indexes
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_SET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAY_BITS = 2'd2;

    // configuration reset values
    localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
    localparam logic [3:0] SET_BITS_RST = 4'd9;
    localparam logic [1:0] WAY_BITS_RST = 2'd0;

    // outcome of one lookup
    typedef struct packed {
        logic              hit;
        logic              fill_random;
        logic [LANE_W-1:0] way;
        logic [LANE_W-1:0] lane;
    } dec_t;

    // fibonacci lfsr, taps 16 14 13 11, shifting right
    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic b;
        b = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {b, v[15:1]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sactl_tag_ram.sv
`default_nettype none

module sactl_tag_ram
    import sactl_pkg::*;
#(
    parameter int ROWS   = 64,
    parameter int ROW_AW = 6,
    parameter int TAG_W  = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [ROW_AW-1:0]            rd_row,
    output logic      [ROW_W-1:0][TAG_W-1:0]  rd_tags,
    output logic      [ROW_W-1:0]             rd_valid,
    input  wire logic                         tag_we,
    input  wire logic                         valid_we,
    input  wire logic [ROW_AW-1:0]            wr_row,
    input  wire logic [ROW_W-1:0][TAG_W-1:0]  wr_tags,
    input  wire logic [ROW_W-1:0]             wr_valid
);

    logic [ROW_W-1:0][TAG_W-1:0] tag_mem [ROWS];
    logic [ROW_W-1:0]            valid_mem [ROWS];

    logic [ROW_W-1:0][TAG_W-1:0] rd_tags_reg;
    logic [ROW_W-1:0]            rd_valid_reg;

    // tag rows, written only on a fill
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_row] <= wr_tags;
        end
        if (rd_en)
        begin
            rd_tags_reg <= tag_mem[rd_row];
        end
    end

    // valid rows, written on a fill and by the clearing pass
    always_ff @(posedge clk)
    begin
        if (valid_we)
        begin
            valid_mem[wr_row] <= wr_valid;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_row];
        end
    end

    assign rd_tags  = rd_tags_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/sactl_way_select.sv
`default_nettype none

module sactl_way_select
    import sactl_pkg::*;
#(
    parameter int TAG_W = 32
) (
    input  wire logic [ROW_W-1:0][TAG_W-1:0] row_tags,
    input  wire logic [ROW_W-1:0]            row_valid,
    input  wire logic [TAG_W-1:0]            tag,
    input  wire logic [1:0]                  wb,
    input  wire logic [LANE_W-1:0]           base,
    input  wire logic [LANE_W-1:0]           victim_bits,
    output dec_t                             dec
);

    logic [LANE_W-1:0] ways_mask;
    logic [ROW_W-1:0]  hit_vec;
    logic [ROW_W-1:0]  empty_vec;
    logic [LANE_W-1:0] hit_way;
    logic [LANE_W-1:0] empty_way;
    logic [LANE_W-1:0] lane;
    logic [LANE_W-1:0] way_sel;

    assign ways_mask = LANE_W'((4'd1 << wb) - 4'd1);

    // compare the ways in use, lanes base..base+ways-1 of the row
    always_comb
    begin
        for (int w = 0; w < ROW_W; w++)
        begin
            lane = base | LANE_W'(w);
            if ((LANE_W'(w) & ~ways_mask) == '0)
            begin
                hit_vec[w]   = row_valid[lane] && (row_tags[lane] == tag);
                empty_vec[w] = !row_valid[lane];
            end
            else
            begin
                hit_vec[w]   = 1'b0;
                empty_vec[w] = 1'b0;
            end
        end
    end

    // lowest matching way and lowest empty way
    always_comb
    begin
        hit_way   = '0;
        empty_way = '0;
        for (int w = ROW_W - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = LANE_W'(w);
            end
            if (empty_vec[w])
            begin
                empty_way = LANE_W'(w);
            end
        end
    end

    // hit, else fill an empty way, else the random victim
    always_comb
    begin
        if (|hit_vec)
        begin
            way_sel = hit_way;
        end
        else if (|empty_vec)
        begin
            way_sel = empty_way;
        end
        else
        begin
            way_sel = victim_bits & ways_mask;
        end
        dec.hit         = |hit_vec;
        dec.fill_random = !(|hit_vec) && !(|empty_vec);
        dec.way         = way_sel;
        dec.lane        = base | way_sel;
    end

endmodule

`default_nettype wire

FILE: rtl/sactl_stats.sv
`default_nettype none

module sactl_stats
    import sactl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire dec_t              dec,
    output logic [LANE_W-1:0]      victim_bits,
    output logic [31:0]            hit_total,
    output logic [31:0]            miss_total
);

    logic [15:0] lfsr_reg;
    logic [15:0] lfsr_next_val;
    logic [31:0] hit_cnt_reg;
    logic [31:0] hit_cnt_next;
    logic [31:0] miss_cnt_reg;
    logic [31:0] miss_cnt_next;

    // saturating counters, lfsr moves only on a random fill
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        lfsr_next_val = lfsr_reg;
        if (step)
        begin
            if (dec.hit)
            begin
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_next = hit_cnt_reg + 32'd1;
                end
            end
            else
            begin
                if (miss_cnt_reg != '1)
                begin
                    miss_cnt_next = miss_cnt_reg + 32'd1;
                end
                if (dec.fill_random)
                begin
                    lfsr_next_val = lfsr_next(lfsr_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg     <= LFSR_SEED;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            lfsr_reg     <= lfsr_next_val;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    assign victim_bits = lfsr_reg[LANE_W-1:0];
    assign hit_total   = hit_cnt_reg;
    assign miss_total  = miss_cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/set_assoc_cache_tag_lookup_top.sv
`default_nettype none

// channel    | direction | handshake              | payload
// -----------+-----------+------------------------+------------------------------------
// address    | in        | addr_valid, addr_stall | address
// result     | out       | res_valid, res_stall   | hit, way_used, set_number,
//            |           |                        | replaced_valid, hit_total, miss_total
// config     | in        | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// one item per cycle while neither side stalls: the tag row read fills the lookup
// stage, which does the compare and the row write back and loads the result register.
// a fill of the row that the next item reads is forwarded to it.
// after reset a clearing pass zeroes the valid bits, one row per cycle, over all
// ENTRIES/8 rows, with addr_stall high; config writes are taken throughout.
// a stalled result holds the lookup stage, which then stalls the address side.

module set_assoc_cache_tag_lookup_top
    import sactl_pkg::*;
#(
    parameter int ENTRIES    = 512,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  addr_valid,
    output logic                       addr_stall,
    input  wire logic [ADDR_WIDTH-1:0] address,

    output logic                       res_valid,
    input  wire logic                  res_stall,
    output logic                       hit,
    output logic [2:0]                 way_used,
    output logic [8:0]                 set_number,
    output logic                       replaced_valid,
    output logic [31:0]                hit_total,
    output logic [31:0]                miss_total,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [3:0]            cfg_data
);

    localparam int ROWS   = ENTRIES / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TAG_W  = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam logic [1:0] WAY_CAP = (MAX_WAYS >= 8) ? 2'd3 :
                                     (MAX_WAYS >= 4) ? 2'd2 :
                                     (MAX_WAYS >= 2) ? 2'd1 : 2'd0;
    localparam logic [SET_W-1:0] ROW_MASK = SET_W'(ROWS - 1);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    // configuration registers
    logic [3:0] offset_bits_reg;
    logic [3:0] set_bits_reg;
    logic [1:0] way_bits_reg;

    // clearing pass
    logic              clearing_reg;
    logic [ROW_AW-1:0] clr_row_reg;

    // address split
    logic [3:0]            sb;
    logic [1:0]            wb;
    logic [ADDR_WIDTH-1:0] block;
    logic [ADDR_WIDTH-1:0] tag_full;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_idx;
    logic [11:0]           line12;
    logic [SET_W-1:0]      row_full;
    logic [ROW_AW-1:0]     rd_row;

    // lookup stage
    logic              s1_valid_reg;
    logic [TAG_W-1:0]  s1_tag_reg;
    logic [SET_W-1:0]  s1_set_reg;
    logic [ROW_AW-1:0] s1_row_reg;
    logic [LANE_W-1:0] s1_base_reg;
    logic [1:0]        s1_wb_reg;
    logic              s1_fwd_reg;
    logic [ROW_W-1:0][TAG_W-1:0] fwd_tags_reg;
    logic [ROW_W-1:0]            fwd_valid_reg;

    // result register
    logic              out_valid_reg;
    logic              hit_reg;
    logic [2:0]        way_reg;
    logic [SET_W-1:0]  set_reg;
    logic              repl_reg;

    logic                        acc;
    logic                        out_free;
    logic                        s1_go;
    logic                        fill;
    logic                        fwd_next;
    logic [ROW_W-1:0][TAG_W-1:0] rd_tags;
    logic [ROW_W-1:0]            rd_valid;
    logic [ROW_W-1:0][TAG_W-1:0] row_tags;
    logic [ROW_W-1:0]            row_valid;
    logic [ROW_W-1:0][TAG_W-1:0] new_tags;
    logic [ROW_W-1:0]            new_valid;
    logic [ROW_AW-1:0]           wr_row;
    logic [ROW_W-1:0]            wr_valid;
    logic                        valid_we;
    logic [LANE_W-1:0]           victim_bits;
    dec_t                        dec;

    // handshakes
    assign out_free   = !out_valid_reg || !res_stall;
    assign s1_go      = s1_valid_reg && out_free;
    assign addr_stall = clearing_reg || (s1_valid_reg && !out_free);
    assign acc        = addr_valid && !addr_stall;
    assign cfg_ready  = 1'b1;

    // split the address into set, tag and row of the line memory
    always_comb
    begin
        sb       = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
        wb       = (way_bits_reg > WAY_CAP) ? WAY_CAP : way_bits_reg;
        block    = address >> offset_bits_reg;
        set_mask = SET_W'((10'd1 << sb) - 10'd1);
        set_idx  = block[SET_W-1:0] & set_mask;
        tag_full = block >> sb;
        line12   = 12'(set_idx) << wb;
        row_full = SET_W'(line12 >> LANE_W);
        rd_row   = ROW_AW'(row_full & ROW_MASK);
    end

    sactl_tag_ram #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW),
        .TAG_W  (TAG_W)
    ) u_tag_ram (
        .clk      (clk),
        .rd_en    (acc),
        .rd_row   (rd_row),
        .rd_tags  (rd_tags),
        .rd_valid (rd_valid),
        .tag_we   (fill),
        .valid_we (valid_we),
        .wr_row   (wr_row),
        .wr_tags  (new_tags),
        .wr_valid (wr_valid)
    );

    // row seen by the lookup, forwarded when the previous item just filled it
    assign row_tags  = s1_fwd_reg ? fwd_tags_reg : rd_tags;
    assign row_valid = s1_fwd_reg ? fwd_valid_reg : rd_valid;

    sactl_way_select #(
        .TAG_W (TAG_W)
    ) u_way_select (
        .row_tags    (row_tags),
        .row_valid   (row_valid),
        .tag         (s1_tag_reg),
        .wb          (s1_wb_reg),
        .base        (s1_base_reg),
        .victim_bits (victim_bits),
        .dec         (dec)
    );

    sactl_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_go),
        .dec         (dec),
        .victim_bits (victim_bits),
        .hit_total   (hit_total),
        .miss_total  (miss_total)
    );

    // row write back on a miss, or a zeroed valid row during the clearing pass
    always_comb
    begin
        new_tags           = row_tags;
        new_tags[dec.lane] = s1_tag_reg;
        new_valid          = row_valid | (ROW_W'(1) << dec.lane);
        fill               = s1_go && !dec.hit;
        valid_we           = fill || clearing_reg;
        wr_row             = clearing_reg ? clr_row_reg : s1_row_reg;
        wr_valid           = clearing_reg ? '0 : new_valid;
        fwd_next           = fill && (s1_row_reg == rd_row);
    end

    // control: config, clearing pass, stage and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            set_bits_reg    <= SET_BITS_RST;
            way_bits_reg    <= WAY_BITS_RST;
            clearing_reg    <= 1'b1;
            clr_row_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_SET_BITS:    set_bits_reg    <= cfg_data;
                    CFG_WAY_BITS:    way_bits_reg    <= cfg_data[1:0];
                    default:         ;
                endcase
            end
            if (clearing_reg)
            begin
                clr_row_reg <= clr_row_reg + ROW_AW'(1);
                if (clr_row_reg == LAST_ROW)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // lookup stage payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_tag_reg    <= tag_full[TAG_W-1:0];
            s1_set_reg    <= set_idx;
            s1_row_reg    <= rd_row;
            s1_base_reg   <= line12[LANE_W-1:0];
            s1_wb_reg     <= wb;
            s1_fwd_reg    <= fwd_next;
            fwd_tags_reg  <= new_tags;
            fwd_valid_reg <= new_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            hit_reg  <= dec.hit;
            way_reg  <= dec.way;
            set_reg  <= s1_set_reg;
            repl_reg <= dec.fill_random;
        end
    end

    assign res_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign way_used       = way_reg;
    assign set_number     = set_reg;
    assign replaced_valid = repl_reg;

endmodule

`default_nettype wire
